@@ sv/bmc_pkg.sv @@
// Shared types and constants of the binary closing block.
package bmc_pkg;

  localparam int CFG_DIM_W  = 11;
  localparam int CFG_PASS_W = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int TDATA_W    = 8;
  localparam int ROW_W      = 12;
  localparam int OUT_ROW_W  = 10;
  localparam int MAX_HEIGHT = 1024;

  localparam logic [CFG_DIM_W-1:0]  RST_IMAGE_WIDTH  = 11'd500;
  localparam logic [CFG_DIM_W-1:0]  RST_IMAGE_HEIGHT = 11'd375;
  localparam logic [CFG_PASS_W-1:0] RST_PASSES       = 4'd5;

  typedef enum logic {
    OP_PIXEL,
    OP_DRAIN
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_DILATE_PASSES,
    REG_ERODE_PASSES
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_BYPASS,
    MODE_DILATE,
    MODE_ERODE
  } cell_mode_t;

  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
  } tok_ctl_t;

endpackage

@@ sv/bmc_ram.sv @@
// Simple dual-port RAM with registered read.
module bmc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/bmc_cell.sv @@
// One 3x3 dilation, erosion or bypass cell of the closing chain, with its two-row line RAM.
module bmc_cell
  import bmc_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int WW = ($clog2(MAX_WIDTH + 1) > CFG_DIM_W) ? $clog2(MAX_WIDTH + 1) : CFG_DIM_W
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  cell_mode_t              mode,
  input  logic [WW-1:0]           img_w,
  input  logic [CFG_DIM_W-1:0]    img_h,
  input  tok_ctl_t                in_ctl,
  input  logic                    in_val,
  input  logic signed [ROW_W-1:0] in_row,
  input  logic [CW-1:0]           in_col,
  output tok_ctl_t                out_ctl,
  output logic                    out_val,
  output logic signed [ROW_W-1:0] out_row,
  output logic [CW-1:0]           out_col
);

  localparam logic signed [ROW_W-1:0] R0 = ROW_W'(0);
  localparam logic signed [ROW_W-1:0] R1 = ROW_W'(1);
  localparam logic signed [ROW_W-1:0] R2 = ROW_W'(2);
  localparam logic signed [ROW_W-1:0] R3 = ROW_W'(3);

  tok_ctl_t                a_ctl;
  logic                    a_val;
  logic signed [ROW_W-1:0] a_row;
  logic [CW-1:0]           a_col;
  logic [1:0]              rd_data;
  logic [2:0]              c0;
  logic [2:0]              c1;
  logic [2:0]              col_new;
  logic signed [ROW_W-1:0] pr;
  logic [CW-1:0]           pc;
  logic [WW-1:0]           pcw;
  logic signed [ROW_W-1:0] hs;
  logic [2:0]              row_ok;
  logic [2:0]              col_ok;
  logic [8:0]              win;
  logic [8:0]              msk;
  logic                    res;
  logic                    bypass;
  logic                    step;
  logic                    rd_en;

  assign bypass = (mode == MODE_BYPASS);
  assign step   = en & a_ctl.valid & ~bypass;
  assign rd_en  = en & in_ctl.valid & ~bypass;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl <= '0;
    end else if (en) begin
      a_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_val <= in_val;
      a_row <= in_row;
      a_col <= in_col;
    end
  end

  bmc_ram #(
    .WIDTH(2),
    .DEPTH(MAX_WIDTH)
  ) u_line (
    .clk  (clk),
    .we   (step),
    .waddr(a_col),
    .wdata({rd_data[0], a_val}),
    .re   (rd_en),
    .raddr(in_col),
    .rdata(rd_data)
  );

  assign col_new = {rd_data[1], rd_data[0], a_val};

  always_ff @(posedge clk) begin
    if (step) begin
      c0 <= c1;
      c1 <= col_new;
    end
  end

  always_comb begin
    if (a_col != '0) begin
      pr = a_row - R1;
      pc = a_col - CW'(1);
    end else begin
      pr = a_row - R2;
      pc = CW'(img_w - WW'(1));
    end
    pcw = WW'(pc);
    hs  = signed'(ROW_W'(img_h));
    row_ok[2] = (pr >= R2) && (pr <= hs - R1);
    row_ok[1] = (pr >= R1) && (pr <= hs - R2);
    row_ok[0] = (pr >= R0) && (pr <= hs - R3);
    col_ok[2] = (pcw >= WW'(2)) && (pcw <= img_w - WW'(1));
    col_ok[1] = (pcw >= WW'(1)) && (pcw <= img_w - WW'(2));
    col_ok[0] = (pcw <= img_w - WW'(3));
    win = {c0, c1, col_new};
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        msk[3 * k + j] = col_ok[k] & row_ok[j];
      end
    end
    case (mode)
      MODE_DILATE: res = |(win & msk);
      MODE_ERODE:  res = &(win | ~msk);
      default:     res = a_val;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (en) begin
      out_ctl <= a_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_val <= res;
      out_row <= bypass ? a_row : pr;
      out_col <= bypass ? a_col : pc;
    end
  end

endmodule

@@ sv/binary_morphological_closing.sv @@
// Binary closing: 2*MAX_PASSES 3x3 cells, dilations then erosions, then bypass cells.
// Throughput: one item (one step per cell) per clock unless the output queue is full.
// Latency: a result leaves (dilations+erosions)*(width+1) items after its pixel, then
// passes through the registers of the cell chain and the output queue register.
// Reset (rst, synchronous): registers to defaults, counters cleared; line RAMs not cleared.
module binary_morphological_closing
  import bmc_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_PASSES = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [TDATA_W-1:0]   s_axis_tdata,   // [0] pixel_on
  input  logic                 s_axis_tuser,   // [0] op
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [TDATA_W-1:0]   m_axis_tdata,   // [0] out_pixel
  output logic                 m_axis_tlast,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DIM_W-1:0] cfg_data
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = ($clog2(MAX_WIDTH + 1) > CFG_DIM_W) ? $clog2(MAX_WIDTH + 1) : CFG_DIM_W;
  localparam int NCELL = 2 * MAX_PASSES;
  localparam int PW    = $clog2(MAX_PASSES + 1);
  localparam int PCW   = (PW > CFG_PASS_W) ? PW : CFG_PASS_W;
  localparam int NW    = $clog2(NCELL + 1);
  localparam int DW    = $clog2(NCELL * (MAX_WIDTH + 1) + 1);
  localparam int FW    = $clog2(MAX_WIDTH * MAX_HEIGHT + NCELL * (MAX_WIDTH + 1));
  localparam int RFW   = ROW_W - 1;
  localparam logic [1:0] OQ_FULL = 2'd2;

  logic [CFG_DIM_W-1:0]  reg_width;
  logic [CFG_DIM_W-1:0]  reg_height;
  logic [CFG_PASS_W-1:0] reg_dilate;
  logic [CFG_PASS_W-1:0] reg_erode;

  logic [WW-1:0]        w_eff;
  logic [CFG_DIM_W-1:0] h_eff;
  logic [PCW-1:0]       nd;
  logic [PCW-1:0]       ne;
  logic [NW-1:0]        npass;
  logic [DW-1:0]        delay;

  logic [FW-1:0]        items_seen;
  logic [CW-1:0]        in_column;
  logic [RFW-1:0]       in_row;
  logic [CW-1:0]        out_column;
  logic [OUT_ROW_W-1:0] out_row;

  logic chain_en;
  logic accept;
  logic in_frame;
  logic ignore;
  logic advance;
  logic live;
  logic last;
  logic cfg_hit;

  tok_ctl_t                ch_ctl [NCELL+1];
  logic                    ch_val [NCELL+1];
  logic signed [ROW_W-1:0] ch_row [NCELL+1];
  logic [CW-1:0]           ch_col [NCELL+1];

  logic       push;
  logic       pop;
  logic [1:0] oq_count;
  logic       oq_pix0;
  logic       oq_last0;
  logic       oq_pix1;
  logic       oq_last1;

  always_comb begin
    if (WW'(reg_width) < WW'(3)) begin
      w_eff = WW'(3);
    end else if (WW'(reg_width) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(reg_width);
    end
    if (reg_height < CFG_DIM_W'(3)) begin
      h_eff = CFG_DIM_W'(3);
    end else if (reg_height > CFG_DIM_W'(MAX_HEIGHT)) begin
      h_eff = CFG_DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = reg_height;
    end
    nd    = (PCW'(reg_dilate) > PCW'(MAX_PASSES)) ? PCW'(MAX_PASSES) : PCW'(reg_dilate);
    ne    = (PCW'(reg_erode) > PCW'(MAX_PASSES)) ? PCW'(MAX_PASSES) : PCW'(reg_erode);
    npass = NW'(nd) + NW'(ne);
    delay = DW'(npass) * (DW'(w_eff) + DW'(1));
  end

  assign chain_en      = (oq_count != OQ_FULL);
  assign s_axis_tready = chain_en;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign in_frame      = (in_row < RFW'(h_eff));
  assign ignore        = in_frame & (op_t'(s_axis_tuser) == OP_DRAIN);
  assign advance       = accept & ~ignore;
  assign live          = (items_seen >= FW'(delay));
  assign last          = live && (out_row == OUT_ROW_W'(h_eff - CFG_DIM_W'(1)))
                         && (WW'(out_column) == w_eff - WW'(1));

  always_comb begin
    case (cfg_reg_t'(cfg_index))
      REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_DILATE_PASSES, REG_ERODE_PASSES: cfg_hit = cfg_we;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_width  <= RST_IMAGE_WIDTH;
      reg_height <= RST_IMAGE_HEIGHT;
      reg_dilate <= RST_PASSES;
      reg_erode  <= RST_PASSES;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:   reg_width  <= cfg_data;
        REG_IMAGE_HEIGHT:  reg_height <= cfg_data;
        REG_DILATE_PASSES: reg_dilate <= cfg_data[CFG_PASS_W-1:0];
        REG_ERODE_PASSES:  reg_erode  <= cfg_data[CFG_PASS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit || (advance && last)) begin
      items_seen <= '0;
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else if (advance) begin
      items_seen <= items_seen + FW'(1);
      if (WW'(in_column) == w_eff - WW'(1)) begin
        in_column <= '0;
        in_row    <= in_row + RFW'(1);
      end else begin
        in_column <= in_column + CW'(1);
      end
      if (live) begin
        if (WW'(out_column) == w_eff - WW'(1)) begin
          out_column <= '0;
          out_row    <= out_row + OUT_ROW_W'(1);
        end else begin
          out_column <= out_column + CW'(1);
        end
      end
    end
  end

  assign ch_ctl[0] = '{valid: advance, emit: live, last: last};
  assign ch_val[0] = s_axis_tdata[0];
  assign ch_row[0] = signed'(ROW_W'(in_row));
  assign ch_col[0] = in_column;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    localparam logic [NW-1:0] IDX = NW'(g);
    cell_mode_t mode;

    always_comb begin
      if (IDX < NW'(nd)) begin
        mode = MODE_DILATE;
      end else if (IDX < npass) begin
        mode = MODE_ERODE;
      end else begin
        mode = MODE_BYPASS;
      end
    end

    bmc_cell #(
      .MAX_WIDTH(MAX_WIDTH)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (chain_en),
      .mode   (mode),
      .img_w  (w_eff),
      .img_h  (h_eff),
      .in_ctl (ch_ctl[g]),
      .in_val (ch_val[g]),
      .in_row (ch_row[g]),
      .in_col (ch_col[g]),
      .out_ctl(ch_ctl[g+1]),
      .out_val(ch_val[g+1]),
      .out_row(ch_row[g+1]),
      .out_col(ch_col[g+1])
    );
  end

  assign push = chain_en & ch_ctl[NCELL].valid & ch_ctl[NCELL].emit;
  assign pop  = m_axis_tvalid & m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_count <= '0;
    end else begin
      case ({push, pop})
        2'b10:   oq_count <= oq_count + 2'd1;
        2'b01:   oq_count <= oq_count - 2'd1;
        default: oq_count <= oq_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && oq_count == 2'd1) begin
        oq_pix0  <= ch_val[NCELL];
        oq_last0 <= ch_ctl[NCELL].last;
      end else begin
        oq_pix0  <= oq_pix1;
        oq_last0 <= oq_last1;
      end
    end else if (push) begin
      if (oq_count == 2'd0) begin
        oq_pix0  <= ch_val[NCELL];
        oq_last0 <= ch_ctl[NCELL].last;
      end else begin
        oq_pix1  <= ch_val[NCELL];
        oq_last1 <= ch_ctl[NCELL].last;
      end
    end
  end

  assign m_axis_tvalid = (oq_count != 2'd0);
  assign m_axis_tdata  = {{(TDATA_W - 1){1'b0}}, oq_pix0};
  assign m_axis_tlast  = oq_last0;

`ifndef SYNTHESIS
  a_oq_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (oq_count != OQ_FULL))
    else $error("result pushed into a full output queue");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (advance && last) |=> (items_seen == '0 && in_row == '0 && out_row == '0))
    else $error("counters not cleared after the last pixel of a frame");

  a_drain_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && ignore && !cfg_we) |=> $stable(items_seen))
    else $error("ignored drain request moved the frame counters");

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    (ch_ctl[NCELL].valid && ch_ctl[NCELL].last) |-> ch_ctl[NCELL].emit)
    else $error("frame end reached the chain tail without a result");
`endif

endmodule
